// ----- src/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg
// Shared constants and types of the heap sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

  // Default capacity of the element store and default element width.
  localparam int DEFAULT_DEPTH       = 64;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // Control from the sequencer to the result register.
  typedef struct packed {
    logic load;  // present a new result
    logic last;  // result is the final one of the run
    logic drop;  // at least one element of the run was discarded
  } out_ctl_t;

endpackage

// ----- src/hse_ctrl.sv -----
// ----------------------------------------------------------------------------
// hse_ctrl
// Element store and sort sequencer. Loads elements, heapsorts them in place
// with one shared comparator and one memory port pair, then reads them out.
// ----------------------------------------------------------------------------
module hse_ctrl import hse_pkg::*; #(
  parameter int DEPTH       = DEFAULT_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_final,
  output logic                          in_ready,
  input  logic                          out_ready,
  output out_ctl_t                      out_ctl,
  output logic signed [VALUE_WIDTH-1:0] out_value
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = CNT_W + 1;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_BUILD_NEXT = 4'd1;
  localparam logic [3:0] S_CUR_WAIT   = 4'd2;
  localparam logic [3:0] S_SIFT       = 4'd3;
  localparam logic [3:0] S_LC_WAIT    = 4'd4;
  localparam logic [3:0] S_RC_WAIT    = 4'd5;
  localparam logic [3:0] S_EXT_NEXT   = 4'd6;
  localparam logic [3:0] S_EXT_LAST   = 4'd7;
  localparam logic [3:0] S_EXT_TOP    = 4'd8;
  localparam logic [3:0] S_OUT_RD     = 4'd9;
  localparam logic [3:0] S_OUT_LD     = 4'd10;

  // Element store.
  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rdata;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic signed [VALUE_WIDTH-1:0] wdata;
  logic                          rd_en;
  logic [AW-1:0]                 raddr;

  // Sequencer registers.
  logic [3:0]                    state, state_next;
  logic                          phase, phase_next;  // 1 while extracting
  logic [AW-1:0]                 node, node_next;
  logic [CNT_W-1:0]              size, size_next;
  logic [CNT_W-1:0]              kk, kk_next;
  logic [CNT_W-1:0]              count, count_next;
  logic                          ovf, ovf_next;
  logic signed [VALUE_WIDTH-1:0] cur, cur_next;
  logic signed [VALUE_WIDTH-1:0] bigv, bigv_next;
  logic [AW-1:0]                 bigi, bigi_next;

  // Child indexes and the shared comparator.
  logic [CW-1:0]                 lc, rc;
  logic                          lc_ok, rc_ok;
  logic signed [VALUE_WIDTH-1:0] cmp_b;
  logic                          cmp_gt;
  logic signed [VALUE_WIDTH-1:0] cand_v;
  logic [AW-1:0]                 cand_i;
  logic                          moved;
  logic                          full;
  logic [CNT_W-1:0]              count_inc;

  assign lc     = (CW'(node) << 1) + CW'(1);
  assign rc     = (CW'(node) << 1) + CW'(2);
  assign lc_ok  = lc < CW'(size);
  assign rc_ok  = rc < CW'(size);
  assign cmp_b  = (state == S_RC_WAIT) ? bigv : cur;
  assign cmp_gt = rdata > cmp_b;
  assign full   = count == CNT_W'(DEPTH);
  assign count_inc = full ? count : count + CNT_W'(1);

  // Largest of node and children seen so far.
  always_comb begin
    if (state == S_RC_WAIT) begin
      cand_v = cmp_gt ? rdata : bigv;
      cand_i = cmp_gt ? rc[AW-1:0] : bigi;
      moved  = cmp_gt || (bigi != node);
    end else begin
      cand_v = cmp_gt ? rdata : cur;
      cand_i = cmp_gt ? lc[AW-1:0] : node;
      moved  = cmp_gt;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    phase_next = phase;
    node_next  = node;
    size_next  = size;
    kk_next    = kk;
    count_next = count;
    ovf_next   = ovf;
    cur_next   = cur;
    bigv_next  = bigv;
    bigi_next  = bigi;
    we         = 1'b0;
    waddr      = node;
    wdata      = cur;
    rd_en      = 1'b0;
    raddr      = node;
    out_ctl    = '0;
    in_ready   = state == S_IDLE;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!full) begin
            we         = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = in_value;
            count_next = count_inc;
          end else begin
            ovf_next = 1'b1;
          end
          if (in_final) begin
            kk_next    = count_inc >> 1;
            phase_next = 1'b0;
            state_next = S_BUILD_NEXT;
          end
        end
      end

      // Heap build: sift down every inner node from the middle to the root.
      S_BUILD_NEXT: begin
        if (kk == '0) begin
          kk_next    = count;
          state_next = S_EXT_NEXT;
        end else begin
          rd_en      = 1'b1;
          raddr      = AW'(kk - CNT_W'(1));
          node_next  = AW'(kk - CNT_W'(1));
          size_next  = count;
          kk_next    = kk - CNT_W'(1);
          state_next = S_CUR_WAIT;
        end
      end

      S_CUR_WAIT: begin
        cur_next   = rdata;
        state_next = S_SIFT;
      end

      // One level of sift-down: fetch the left child or settle the value.
      S_SIFT: begin
        if (lc_ok) begin
          rd_en      = 1'b1;
          raddr      = lc[AW-1:0];
          state_next = S_LC_WAIT;
        end else begin
          we         = 1'b1;
          state_next = phase ? S_EXT_NEXT : S_BUILD_NEXT;
        end
      end

      S_LC_WAIT, S_RC_WAIT: begin
        if (state == S_LC_WAIT && rc_ok) begin
          bigv_next  = cand_v;
          bigi_next  = cand_i;
          rd_en      = 1'b1;
          raddr      = rc[AW-1:0];
          state_next = S_RC_WAIT;
        end else if (moved) begin
          // The larger child moves up into the hole.
          we         = 1'b1;
          wdata      = cand_v;
          node_next  = cand_i;
          state_next = S_SIFT;
        end else begin
          we         = 1'b1;
          state_next = phase ? S_EXT_NEXT : S_BUILD_NEXT;
        end
      end

      // Extraction: move the root behind the shrinking heap.
      S_EXT_NEXT: begin
        if (kk < CNT_W'(2)) begin
          kk_next    = '0;
          state_next = S_OUT_RD;
        end else begin
          rd_en      = 1'b1;
          raddr      = AW'(kk - CNT_W'(1));
          state_next = S_EXT_LAST;
        end
      end

      S_EXT_LAST: begin
        cur_next   = rdata;
        rd_en      = 1'b1;
        raddr      = '0;
        state_next = S_EXT_TOP;
      end

      S_EXT_TOP: begin
        we         = 1'b1;
        waddr      = AW'(kk - CNT_W'(1));
        wdata      = rdata;
        node_next  = '0;
        size_next  = kk - CNT_W'(1);
        kk_next    = kk - CNT_W'(1);
        phase_next = 1'b1;
        state_next = S_SIFT;
      end

      // Read-out in ascending order.
      S_OUT_RD: begin
        rd_en      = 1'b1;
        raddr      = kk[AW-1:0];
        state_next = S_OUT_LD;
      end

      S_OUT_LD: begin
        if (out_ready) begin
          out_ctl.load = 1'b1;
          out_ctl.last = kk == count - CNT_W'(1);
          out_ctl.drop = ovf;
          if (kk == count - CNT_W'(1)) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_IDLE;
          end else begin
            kk_next    = kk + CNT_W'(1);
            state_next = S_OUT_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_value = rdata;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      phase <= phase_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    node <= node_next;
    size <= size_next;
    kk   <= kk_next;
    cur  <= cur_next;
    bigv <= bigv_next;
    bigi <= bigi_next;
  end

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/hse_out.sv -----
// ----------------------------------------------------------------------------
// hse_out
// Result register. Holds one sorted element until the downstream side takes
// it, and accepts the next one in the cycle the current one leaves.
// ----------------------------------------------------------------------------
module hse_out import hse_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  out_ctl_t                      ctl,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          ready,
  output logic                          valid,
  input  logic                          taken,
  output logic signed [VALUE_WIDTH-1:0] held_value,
  output logic                          held_last,
  output logic                          held_drop
);

  assign ready = !valid || taken;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (taken) begin
      valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held_value <= value;
      held_last  <= ctl.last;
      held_drop  <= ctl.drop;
    end
  end

endmodule

// ----- src/heap_sort_engine_core.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine_core
// Input: one element per cycle while the sequencer is idle; on the last
// element a heapsort runs in place, one sift-down level at a time.
// Output: each result is read through the single read port before it is loaded.
// Reset: synchronous, clears count, overflow flag and sequencer; the element
// store is not cleared.
// ----------------------------------------------------------------------------
module heap_sort_engine_core import hse_pkg::*; #(
  parameter int DEPTH       = DEFAULT_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
  parameter int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // sample_value
  input  logic              s_tlast,   // final_item
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // sorted_value
  output logic              m_tlast,   // final_result
  output logic              m_tuser    // dropped_flag
);

  out_ctl_t                      ctl;
  logic signed [VALUE_WIDTH-1:0] rd_value;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic                          out_ready;

  hse_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_value  (s_tdata[VALUE_WIDTH-1:0]),
    .in_final  (s_tlast),
    .in_ready  (s_tready),
    .out_ready (out_ready),
    .out_ctl   (ctl),
    .out_value (rd_value)
  );

  hse_out #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .value      (rd_value),
    .ready      (out_ready),
    .valid      (m_tvalid),
    .taken      (m_tready),
    .held_value (res_value),
    .held_last  (m_tlast),
    .held_drop  (m_tuser)
  );

  assign m_tdata = DATA_W'($unsigned(res_value));

  // A result is loaded only when the result register can take it.
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> out_ready)
    else $error("result loaded while the result register is occupied");

  // A final element starts the sort, so no input is taken next cycle.
  a_sort_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after a final element");

  // After the last result of a run is loaded the block takes input again.
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load && ctl.last |=> s_tready)
    else $error("sequencer not idle after the last result");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the heap sort engine. Runs of signed samples are streamed in,
// each closed by a transfer with tlast set. A scoreboard keeps its own copy of
// the collected run, sorts it when the closing sample is accepted, and checks
// every result that leaves the engine, including the last and drop markers.
// ----------------------------------------------------------------------------
module tb_top;
  import hse_pkg::*;

  localparam int DEPTH  = DEFAULT_DEPTH;
  localparam int VW     = DEFAULT_VALUE_WIDTH;
  localparam int DATA_W = ((VW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_START = 1500;
  localparam int QUIET_END   = 4000;

  // Value mixes used to fill a run.
  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES} spread_t;

  typedef struct {
    logic [VW-1:0] value;
    bit            last;
    bit            drain;  // wait for all results before offering this sample
  } sample_t;

  typedef struct {
    logic [VW-1:0] sorted_value;
    bit            final_result;
    bit            dropped_flag;
  } sorted_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  sample_t pending_q[$];
  sorted_t sorted_q[$];
  sample_t next_sample;
  sorted_t oldest;

  // Scoreboard copy of the run being collected.
  logic signed [VW-1:0] run_store [DEPTH];
  int  run_count = 0;
  bit  run_overflow = 1'b0;

  bit  in_fire = 1'b0;
  int  cycle = 0;
  int  errors = 0;
  int  samples_taken = 0;
  int  results_seen = 0;
  int  runs_sorted = 0;
  int  overflow_runs = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  quiet;

  heap_sort_engine_core #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  assign quiet = (cycle >= QUIET_START) && (cycle < QUIET_END);

  // Sort the collected run in ascending signed order and queue its results.
  task sort_run();
    logic signed [VW-1:0] key;
    int j;
    sorted_t res;
    for (int i = 1; i < run_count; i++) begin
      key = run_store[i];
      j = i - 1;
      while (j >= 0 && run_store[j] > key) begin
        run_store[j + 1] = run_store[j];
        j--;
      end
      run_store[j + 1] = key;
    end
    for (int i = 0; i < run_count; i++) begin
      res.sorted_value = run_store[i];
      res.final_result = (i == run_count - 1);
      res.dropped_flag = run_overflow;
      sorted_q.push_back(res);
    end
    runs_sorted++;
    if (run_overflow) overflow_runs++;
    run_count = 0;
    run_overflow = 1'b0;
  endtask

  // Store one accepted sample, or note that it was dropped for lack of room.
  task collect_sample(input logic [VW-1:0] value, input bit last);
    if (run_count < DEPTH) begin
      run_store[run_count] = value;
      run_count++;
    end else begin
      run_overflow = 1'b1;
    end
    samples_taken++;
    if (last) sort_run();
  endtask

  // Input side: track accepted transfers and feed the scoreboard.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) collect_sample(s_tdata[VW-1:0], s_tlast);
    end
  end

  // Output side: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        $error("unexpected result: sorted_value %0d", $signed(m_tdata[VW-1:0]));
        errors++;
      end else begin
        oldest = sorted_q.pop_front();
        if (m_tdata[VW-1:0] !== oldest.sorted_value) begin
          $error("sorted_value: expected %0d, actual %0d",
                 $signed(oldest.sorted_value), $signed(m_tdata[VW-1:0]));
          errors++;
        end
        if (m_tlast !== oldest.final_result) begin
          $error("final_result: expected %0d, actual %0d", oldest.final_result, m_tlast);
          errors++;
        end
        if (m_tuser !== oldest.dropped_flag) begin
          $error("dropped_flag: expected %0d, actual %0d", oldest.dropped_flag, m_tuser);
          errors++;
        end
      end
    end
  end

  // Driver: offers pending samples, with random gaps and drain pauses.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_q.size() > 0 && !(pending_q[0].drain && sorted_q.size() != 0)
          && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        next_sample = pending_q.pop_front();
        s_tdata  <= DATA_W'(next_sample.value);
        s_tlast  <= next_sample.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once a large run is
  // being presented, so that the engine backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && m_tvalid && sorted_q.size() >= 48) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", sorted_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [VW-1:0] pick_value(spread_t spread);
    logic [VW-1:0] v;
    case (spread)
      SPREAD_NARROW: v = VW'($urandom_range(8) - 4);
      SPREAD_EDGES: begin
        case ($urandom_range(4))
          0: v = {1'b1, {(VW-1){1'b0}}};
          1: v = {1'b0, {(VW-1){1'b1}}};
          2: v = '0;
          3: v = '1;
          default: v = VW'($urandom);
        endcase
      end
      default: v = VW'($urandom);
    endcase
    return v;
  endfunction

  task add_sample(input logic [VW-1:0] value, input bit last, input bit drain);
    sample_t s;
    s.value = value;
    s.last  = last;
    s.drain = drain;
    pending_q.push_back(s);
  endtask

  task add_run(input int len, input spread_t spread, input bit drain);
    for (int i = 0; i < len; i++)
      add_sample(pick_value(spread), i == len - 1, drain && i == 0);
  endtask

  initial begin
    int queued;
    int len;

    // Directed runs: single extremes, mixed extremes, equal values, order.
    add_sample({1'b1, {(VW-1){1'b0}}}, 1'b1, 1'b0);
    add_sample({1'b0, {(VW-1){1'b1}}}, 1'b1, 1'b0);
    add_sample({1'b0, {(VW-1){1'b1}}}, 1'b0, 1'b1);
    add_sample({1'b1, {(VW-1){1'b0}}}, 1'b0, 1'b0);
    add_sample('0, 1'b0, 1'b0);
    add_sample('1, 1'b1, 1'b0);
    add_sample(VW'(5), 1'b0, 1'b0);
    add_sample(VW'(5), 1'b0, 1'b0);
    add_sample(VW'(5), 1'b1, 1'b0);
    add_sample({1'b1, {(VW-1){1'b0}}}, 1'b0, 1'b0);
    add_sample({1'b1, {(VW-1){1'b0}}}, 1'b1, 1'b0);
    for (int i = 2; i >= -2; i--) add_sample(VW'(i), i == -2, 1'b0);

    // Random runs: mostly short, one exactly full, one that overflows
    // so that its closing sample is dropped as well.
    queued = 0;
    for (int r = 0; r < 4; r++) begin
      len = $urandom_range(1, 12);
      add_run(len, spread_t'($urandom_range(2)), $urandom_range(7) == 0);
      queued += len;
    end
    add_run(DEPTH, SPREAD_FULL, 1'b0);
    queued += DEPTH;
    for (int r = 0; r < 3; r++) begin
      len = $urandom_range(1, 12);
      add_run(len, spread_t'($urandom_range(2)), 1'b0);
      queued += len;
    end
    add_run(DEPTH + 3, SPREAD_NARROW, 1'b1);
    queued += DEPTH + 3;
    while (queued < 200) begin
      len = $urandom_range(1, 12);
      add_run(len, spread_t'($urandom_range(2)), $urandom_range(7) == 0);
      queued += len;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && !s_tvalid);
    wait (sorted_q.size() == 0);
    repeat (200) @(posedge clk);

    $display("Sorted %0d runs (%0d with dropped samples) from %0d samples; %0d results checked.",
             runs_sorted, overflow_runs, samples_taken, results_seen);
    if (errors == 0 && sorted_q.size() == 0 && run_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
